/* rtl/bmpa_pkg.sv */
// Shared constants and types for the bump allocator with record table.
// Holds field widths, stream packing, request kinds and status codes.
// No dependencies.
`default_nettype none

package bmpa_pkg;

   // default sizing of the pool and the record table
   localparam int POOL_BYTES_DEF  = 4096;
   localparam int MAX_RECORDS_DEF = 64;

   // fixed field widths on the stream ports
   localparam int SIZE_W   = 13;
   localparam int ADDR_W   = 13;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 7;

   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 64;

   // default record entry width: in-use flag, offset, size
   localparam int ENTRY_W_DEF = 1 + $clog2(POOL_BYTES_DEF + 1) + SIZE_W;

   typedef enum logic {
      REQ_ALLOC   = 1'b0,
      REQ_RELEASE = 1'b1
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_NOSPACE  = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_NULL     = 3'd4
   } status_type;

endpackage

`default_nettype wire

/* rtl/bmpa_rec_mem.sv */
// Record table storage: one write port, one read port, registered read data.
// Depends on bmpa_pkg for default sizing.
`default_nettype none

module bmpa_rec_mem #(
   parameter int DEPTH = bmpa_pkg::MAX_RECORDS_DEF,
   parameter int WIDTH = bmpa_pkg::ENTRY_W_DEF,
   parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_idx,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [IDX_W-1:0] rd_idx,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data <= mem[rd_idx];
   end

endmodule

`default_nettype wire

/* rtl/bump_allocator_with_record_table_unit.sv */
// Bump allocator with a table of allocation records, stream ports in and out.
// Allocate, null or empty-table release: S_IDLE goes to S_EMIT, which loads the response register.
// Release: S_SEARCH reads the records from record 0 on and stops at the first live match or
// at the last record, then goes to S_EMIT; one record read per cycle.
// One request in flight; a new one is taken while a response waits, then holds until it drains.
// Synchronous reset empties the pool and the table at once; no clearing pass.
`default_nettype none

module bump_allocator_with_record_table_unit #(
   parameter int POOL_BYTES  = bmpa_pkg::POOL_BYTES_DEF,
   parameter int MAX_RECORDS = bmpa_pkg::MAX_RECORDS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [12:0] request_size, [25:13] release_address, [31:26] zero
   input  wire logic [bmpa_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [0] req_type, [1] address_is_null
   input  wire logic [bmpa_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [2:0] status, [15:3] granted_address, [28:16] released_size,
   // [41:29] bytes_used, [54:42] bytes_available, [61:55] record_count, [63:62] zero
   output logic      [bmpa_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   // widths that follow from the pool and table sizes
   localparam int OFF_W  = $clog2(POOL_BYTES + 1);
   localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
   localparam int IDX_W  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int SIZE_W = bmpa_pkg::SIZE_W;
   localparam int ADDR_W = bmpa_pkg::ADDR_W;
   localparam int ENT_W  = 1 + OFF_W + SIZE_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_EMIT
   } state_type;

   // control state
   state_type                       state_ff, state_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [OFF_W-1:0]                bump_ff, bump_in;
   logic [CNT_W-1:0]                count_ff, count_in;

   // payload state
   logic [IDX_W-1:0]                rd_idx_ff, rd_idx_in;
   logic [ADDR_W-1:0]               key_ff, key_in;
   bmpa_pkg::status_type            res_status_ff, res_status_in;
   logic [ADDR_W-1:0]               res_granted_ff, res_granted_in;
   logic [SIZE_W-1:0]               res_released_ff, res_released_in;
   logic [bmpa_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // record memory port
   logic                            mem_we;
   logic [IDX_W-1:0]                mem_waddr;
   logic [ENT_W-1:0]                mem_wdata;
   logic [IDX_W-1:0]                mem_raddr;
   logic [ENT_W-1:0]                mem_rdata;

   // request fields
   bmpa_pkg::req_kind_type          in_kind;
   logic                            in_null;
   logic [SIZE_W-1:0]               in_size;
   logic [ADDR_W-1:0]               in_addr;
   logic                            req_accept;

   // decode helpers
   logic [31:0]                     fit_sum;
   logic                            table_full;
   logic                            no_fit;
   logic [IDX_W-1:0]                next_idx;
   logic                            last_idx;
   logic                            rd_in_use;
   logic [OFF_W-1:0]                rd_addr;
   logic [SIZE_W-1:0]               rd_size;
   logic                            hit;

   assign in_kind    = bmpa_pkg::req_kind_type'(req_tuser[0]);
   assign in_null    = req_tuser[1];
   assign in_size    = req_tdata[SIZE_W-1:0];
   assign in_addr    = req_tdata[SIZE_W +: ADDR_W];

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // allocation fit test on the current bump offset
   assign fit_sum    = 32'(bump_ff) + 32'(in_size);
   assign table_full = (32'(count_ff) >= 32'(MAX_RECORDS));
   assign no_fit     = (fit_sum > 32'(POOL_BYTES));

   // scan bookkeeping: rd_idx_ff names the record whose data arrives this cycle
   assign next_idx   = rd_idx_ff + IDX_W'(1);
   assign last_idx   = ((32'(rd_idx_ff) + 32'd1) >= 32'(count_ff));
   assign rd_in_use  = mem_rdata[ENT_W-1];
   assign rd_addr    = mem_rdata[SIZE_W +: OFF_W];
   assign rd_size    = mem_rdata[SIZE_W-1:0];
   assign hit        = rd_in_use && (32'(rd_addr) == 32'(key_ff));

   // prefetch the next record every cycle; record 0 while idle
   assign mem_raddr  = (state_ff == S_IDLE) ? '0 : next_idx;

   always_comb begin
      state_in        = state_ff;
      rsp_valid_in    = rsp_valid_ff;
      bump_in         = bump_ff;
      count_in        = count_ff;
      rd_idx_in       = rd_idx_ff;
      key_in          = key_ff;
      res_status_in   = res_status_ff;
      res_granted_in  = res_granted_ff;
      res_released_in = res_released_ff;
      rsp_data_in     = rsp_data_ff;
      mem_we          = 1'b0;
      mem_waddr       = rd_idx_ff;
      mem_wdata       = {1'b0, rd_addr, rd_size};

      // drop the response once the sink takes it
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               res_granted_in  = '0;
               res_released_in = '0;
               state_in        = S_EMIT;
               if (in_kind == bmpa_pkg::REQ_ALLOC) begin
                  if (table_full) begin
                     res_status_in = bmpa_pkg::ST_FULL;
                  end else if (no_fit) begin
                     res_status_in = bmpa_pkg::ST_NOSPACE;
                  end else begin
                     // grant the offset, bump it and append a record
                     res_status_in  = bmpa_pkg::ST_OK;
                     res_granted_in = ADDR_W'(bump_ff);
                     bump_in        = OFF_W'(fit_sum);
                     count_in       = count_ff + CNT_W'(1);
                     mem_we         = 1'b1;
                     mem_waddr      = count_ff[IDX_W-1:0];
                     mem_wdata      = {1'b1, bump_ff, in_size};
                  end
               end else if (in_null) begin
                  res_status_in = bmpa_pkg::ST_NULL;
               end else if (count_ff == '0) begin
                  res_status_in = bmpa_pkg::ST_NOTFOUND;
               end else begin
                  // record 0 is being read this cycle; scan from there
                  key_in    = in_addr;
                  rd_idx_in = '0;
                  state_in  = S_SEARCH;
               end
            end
         end

         S_SEARCH: begin
            if (hit) begin
               // write back the matching record with its in-use mark cleared
               mem_we          = 1'b1;
               mem_waddr       = rd_idx_ff;
               mem_wdata       = {1'b0, rd_addr, rd_size};
               res_status_in   = bmpa_pkg::ST_OK;
               res_released_in = rd_size;
               state_in        = S_EMIT;
            end else if (last_idx) begin
               res_status_in = bmpa_pkg::ST_NOTFOUND;
               state_in      = S_EMIT;
            end else begin
               rd_idx_in = next_idx;
            end
         end

         S_EMIT: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00,
                               bmpa_pkg::COUNT_W'(count_ff),
                               ADDR_W'(32'(POOL_BYTES) - 32'(bump_ff)),
                               ADDR_W'(bump_ff),
                               res_released_ff,
                               res_granted_ff,
                               res_status_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         bump_ff      <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bump_ff      <= bump_in;
         count_ff     <= count_in;
      end
      rd_idx_ff       <= rd_idx_in;
      key_ff          <= key_in;
      res_status_ff   <= res_status_in;
      res_granted_ff  <= res_granted_in;
      res_released_ff <= res_released_in;
      rsp_data_ff     <= rsp_data_in;
   end

   bmpa_rec_mem #(
      .DEPTH (MAX_RECORDS),
      .WIDTH (ENT_W),
      .IDX_W (IDX_W)
   ) u_rec_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_idx  (mem_waddr),
      .wr_data (mem_wdata),
      .rd_idx  (mem_raddr),
      .rd_data (mem_rdata)
   );

   // the record count only grows
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff >= $past(count_ff)))
      else $error("record count decreased");

   // the bump offset never passes the end of the pool
   a_bump_in_pool: assert property (@(posedge clock) disable iff (reset)
      (32'(bump_ff) <= 32'(POOL_BYTES)))
      else $error("bump offset beyond pool");

   // the table never holds more records than it has slots
   a_count_in_table: assert property (@(posedge clock) disable iff (reset)
      (32'(count_ff) <= 32'(MAX_RECORDS)))
      else $error("record count beyond table");

   // the scan only looks at records that were written
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> (32'(rd_idx_ff) < 32'(count_ff)))
      else $error("scan past record count");

endmodule

`default_nettype wire

/* dv/bump_allocator_with_record_table_unit_tb.sv */
// Self-checking testbench for the bump allocator with record table unit.
// Predicts each response from its own copy of the pool offset and record table.
// Depends on bmpa_pkg and bump_allocator_with_record_table_unit.
`timescale 1ns / 100ps

module bump_allocator_with_record_table_unit_tb;

   localparam int POOL_BYTES  = bmpa_pkg::POOL_BYTES_DEF;
   localparam int MAX_RECS    = bmpa_pkg::MAX_RECORDS_DEF;
   localparam int ITEM_TARGET = 1150;
   localparam int ADDR_W      = bmpa_pkg::ADDR_W;
   localparam int SIZE_W      = bmpa_pkg::SIZE_W;
   localparam int COUNT_W     = bmpa_pkg::COUNT_W;

   typedef struct packed {
      bmpa_pkg::status_type status;
      logic [ADDR_W-1:0]    granted;
      logic [SIZE_W-1:0]    released;
      logic [ADDR_W-1:0]    used;
      logic [ADDR_W-1:0]    avail;
      logic [COUNT_W-1:0]   count;
   } alloc_outcome_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [bmpa_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic [bmpa_pkg::REQ_TUSER_W-1:0] req_tuser = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b1;
   logic [bmpa_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   // predicted allocator state
   logic [ADDR_W-1:0]  pool_offset = '0;
   logic [COUNT_W-1:0] rec_total = '0;
   logic [ADDR_W-1:0]  rec_addr [MAX_RECS];
   logic [SIZE_W-1:0]  rec_size [MAX_RECS];
   bit                 rec_live [MAX_RECS];

   alloc_outcome_type pending_outcomes[$];
   alloc_outcome_type oldest;
   bit                steady_run = 1'b0;
   int                requests_sent = 0;
   int                responses_checked = 0;
   int                mismatch_count = 0;
   int                status_tally[5] = '{default: 0};

   bump_allocator_with_record_table_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   initial begin
      #4_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic bit idle_now();
      return !steady_run && ($urandom_range(99) < 6);
   endfunction

   // Apply one request to the predicted state and return the response it causes.
   function automatic alloc_outcome_type apply_request(bmpa_pkg::req_kind_type kind,
                                                       logic [SIZE_W-1:0] size,
                                                       logic [ADDR_W-1:0] addr, bit is_null);
      alloc_outcome_type res;
      int i;
      bit hit;
      res = '0;
      hit = 1'b0;
      if (kind == bmpa_pkg::REQ_ALLOC) begin
         if (rec_total >= MAX_RECS) begin
            res.status = bmpa_pkg::ST_FULL;
         end else if (int'(pool_offset) + int'(size) > POOL_BYTES) begin
            res.status = bmpa_pkg::ST_NOSPACE;
         end else begin
            res.granted = pool_offset;
            rec_addr[rec_total] = pool_offset;
            rec_size[rec_total] = size;
            rec_live[rec_total] = 1'b1;
            pool_offset = pool_offset + size;
            rec_total = rec_total + 1'b1;
            res.status = bmpa_pkg::ST_OK;
         end
      end else if (is_null) begin
         res.status = bmpa_pkg::ST_NULL;
      end else begin
         res.status = bmpa_pkg::ST_NOTFOUND;
         // lowest-indexed live record wins when addresses repeat
         for (i = 0; i < int'(rec_total) && !hit; i++) begin
            if (rec_live[i] && rec_addr[i] == addr) begin
               rec_live[i] = 1'b0;
               res.released = rec_size[i];
               res.status = bmpa_pkg::ST_OK;
               hit = 1'b1;
            end
         end
      end
      res.used = pool_offset;
      res.avail = ADDR_W'(POOL_BYTES - int'(pool_offset));
      res.count = rec_total;
      return res;
   endfunction

   // Present one request from a falling edge and hold it until accepted.
   task automatic send_request(bmpa_pkg::req_kind_type kind, logic [SIZE_W-1:0] size,
                               logic [ADDR_W-1:0] addr, bit is_null);
      @(negedge clock);
      while (idle_now()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, addr, size};
      req_tuser  <= {is_null, kind};
      do begin
         @(posedge clock);
      end while (req_tready !== 1'b1);
      pending_outcomes.push_back(apply_request(kind, size, addr, is_null));
      requests_sent++;
   endtask

   // Drop valid and hold off until every predicted response has arrived.
   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(string field, int got, int want);
      if (mismatch_count < 40)
         $display("[%0t] response %0d: %s got %0d, want %0d",
                  $realtime, responses_checked, field, got, want);
      mismatch_count++;
   endtask

   function automatic logic [ADDR_W-1:0] known_address();
      return (rec_total == 0) ? '0 : rec_addr[$urandom_range(int'(rec_total) - 1)];
   endfunction

   // Empty table: releases find nothing, null release is ignored.
   task automatic test_empty_table();
      send_request(bmpa_pkg::REQ_RELEASE, 13'd4096, 13'd0, 1'b0);
      send_request(bmpa_pkg::REQ_RELEASE, 13'd0, 13'd4096, 1'b1);
      send_request(bmpa_pkg::REQ_RELEASE, 13'd8, 13'd4096, 1'b0);
   endtask

   // Zero-size allocate shares its address with the next one; release order follows index.
   task automatic test_zero_size_and_duplicates();
      send_request(bmpa_pkg::REQ_ALLOC, 13'd0, 13'd4096, 1'b1);
      send_request(bmpa_pkg::REQ_ALLOC, 13'd100, 13'd0, 1'b0);
      send_request(bmpa_pkg::REQ_RELEASE, 13'd4096, 13'd0, 1'b1);
      send_request(bmpa_pkg::REQ_RELEASE, 13'd4096, 13'd0, 1'b0);
      send_request(bmpa_pkg::REQ_RELEASE, 13'd0, 13'd0, 1'b0);
      send_request(bmpa_pkg::REQ_RELEASE, 13'd0, 13'd0, 1'b0);
   endtask

   task automatic test_no_space();
      send_request(bmpa_pkg::REQ_ALLOC, 13'd4096, 13'd0, 1'b0);
      send_request(bmpa_pkg::REQ_ALLOC, 13'd3997, 13'd4095, 1'b1);
   endtask

   // Fill the table with small regions mixed with releases, then exhaust space exactly
   // and overflow the table.
   task automatic test_fill_table();
      int pick;
      steady_run = 1'b0;
      while (rec_total < MAX_RECS - 3) begin
         pick = $urandom_range(99);
         if (pick < 8)
            send_request(bmpa_pkg::REQ_ALLOC, 13'd0, 13'($urandom_range(POOL_BYTES)),
                         1'($urandom()));
         else if (pick < 55)
            send_request(bmpa_pkg::REQ_ALLOC, 13'($urandom_range(60)),
                         13'($urandom_range(POOL_BYTES)), 1'($urandom()));
         else if (pick < 65)
            // just past what is left; offset is nonzero here
            send_request(bmpa_pkg::REQ_ALLOC,
                         13'($urandom_range(POOL_BYTES, POOL_BYTES - int'(pool_offset) + 1)),
                         13'($urandom_range(POOL_BYTES)), 1'($urandom()));
         else if (pick < 85)
            send_request(bmpa_pkg::REQ_RELEASE, 13'($urandom_range(POOL_BYTES)),
                         known_address(), 1'b0);
         else if (pick < 93)
            send_request(bmpa_pkg::REQ_RELEASE, 13'($urandom_range(POOL_BYTES)),
                         13'($urandom_range(POOL_BYTES)), 1'b0);
         else
            send_request(bmpa_pkg::REQ_RELEASE, 13'($urandom_range(POOL_BYTES)),
                         13'($urandom_range(POOL_BYTES)), 1'b1);
      end
      send_request(bmpa_pkg::REQ_ALLOC, 13'(POOL_BYTES - int'(pool_offset)), 13'd0, 1'b0);
      send_request(bmpa_pkg::REQ_ALLOC, 13'd1, 13'd0, 1'b0);
      send_request(bmpa_pkg::REQ_ALLOC, 13'd0, 13'd0, 1'b0);
      send_request(bmpa_pkg::REQ_RELEASE, 13'd0, 13'd4096, 1'b0);
      send_request(bmpa_pkg::REQ_ALLOC, 13'd0, 13'd0, 1'b0);
      send_request(bmpa_pkg::REQ_ALLOC, 13'd4096, 13'd0, 1'b0);
      send_request(bmpa_pkg::REQ_ALLOC, 13'd0, 13'd0, 1'b0);
   endtask

   // Full table: mostly releases that scan the records up to a match or to the end, some refused allocates.
   task automatic test_full_table();
      int pick;
      int start_count;
      start_count = requests_sent;
      while (requests_sent < ITEM_TARGET) begin
         steady_run = (requests_sent - start_count) < 200;
         pick = $urandom_range(99);
         if (pick < 20)
            send_request(bmpa_pkg::REQ_ALLOC, 13'($urandom_range(POOL_BYTES)),
                         13'($urandom_range(POOL_BYTES)), 1'($urandom()));
         else if (pick < 80)
            send_request(bmpa_pkg::REQ_RELEASE, 13'($urandom_range(POOL_BYTES)),
                         known_address(), 1'b0);
         else if (pick < 90)
            send_request(bmpa_pkg::REQ_RELEASE, 13'($urandom_range(POOL_BYTES)),
                         13'($urandom_range(POOL_BYTES)), 1'b0);
         else
            send_request(bmpa_pkg::REQ_RELEASE, 13'($urandom_range(POOL_BYTES)),
                         13'($urandom_range(POOL_BYTES)), 1'b1);
      end
      steady_run = 1'b0;
   endtask

   always @(negedge clock) begin
      rsp_tready <= !idle_now();
   end

   // Compare each accepted response with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected response, status", int'(rsp_tdata[2:0]), -1);
         end else begin
            oldest = pending_outcomes.pop_front();
            if (rsp_tdata[2:0] !== oldest.status)
               report_mismatch("status", int'(rsp_tdata[2:0]), int'(oldest.status));
            if (rsp_tdata[15:3] !== oldest.granted)
               report_mismatch("granted_address", int'(rsp_tdata[15:3]), int'(oldest.granted));
            if (rsp_tdata[28:16] !== oldest.released)
               report_mismatch("released_size", int'(rsp_tdata[28:16]), int'(oldest.released));
            if (rsp_tdata[41:29] !== oldest.used)
               report_mismatch("bytes_used", int'(rsp_tdata[41:29]), int'(oldest.used));
            if (rsp_tdata[54:42] !== oldest.avail)
               report_mismatch("bytes_available", int'(rsp_tdata[54:42]), int'(oldest.avail));
            if (rsp_tdata[61:55] !== oldest.count)
               report_mismatch("record_count", int'(rsp_tdata[61:55]), int'(oldest.count));
            status_tally[int'(oldest.status)]++;
         end
         responses_checked++;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_zero_size_and_duplicates();
      test_no_space();
      wait_for_drain();
      test_fill_table();
      wait_for_drain();
      test_full_table();
      wait_for_drain();
      repeat (MAX_RECS + 8) @(posedge clock);
      $display("Ran %0d requests through fill, exact exhaustion and full-table phases.",
               requests_sent);
      $display("Responses: %0d ok, %0d table full, %0d out of space, %0d not found, %0d null",
               status_tally[int'(bmpa_pkg::ST_OK)], status_tally[int'(bmpa_pkg::ST_FULL)],
               status_tally[int'(bmpa_pkg::ST_NOSPACE)],
               status_tally[int'(bmpa_pkg::ST_NOTFOUND)],
               status_tally[int'(bmpa_pkg::ST_NULL)]);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
